// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file rpi_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rpi_pkg.sv -----
// Types and constants of the range permutation iterator.
// No dependencies; used by rpi_perm, the core and the checker.
package rpi_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
  localparam logic [31:0] COUNT_MAX = 32'h8000_0000;
  localparam logic [4:0]  BITS_MAX  = 5'd31;

  typedef enum logic [1:0] {
    MODE_KEY     = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_NEXT    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SHUFFLE = 2'd0,
    CFG_START   = 2'd1,
    CFG_COUNT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PERM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        en;
    logic [6:0]  index;
    logic [31:0] word;
  } key_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] seed;
    logic [4:0]  bits;
  } perm_ctrl_t;

endpackage

// ----- rtl/range_permutation_iterator_core.sv -----
// Range permutation iterator core: hands out each value of [start, start+count) once.
// Depends on rpi_pkg and rpi_perm.
//
// Each "next" request returns start plus an index, added modulo 2^32, and the
// number of members still to come; once the range is used up it answers
// exhausted with zero fields. With shuffling on, the index is a keyed
// variable-width TEA-style permutation of the walk counter over the smallest
// power-of-two domain holding the count; codes at or above the count are
// skipped by cycle walking. One cipher round runs per cycle, paced by the
// key memory read (one word per round), and each skipped code costs a
// further set of ROUNDS rounds (default 32). A sequential next passes
// through the result register into the output register; key loads, restarts
// and unused modes are taken in the idle state. Requests are handled one at a time; a finished
// result sits in the output register while the next request is accepted.
// After a range_count write the domain width is found one bit per cycle,
// during which no request is accepted.
module range_permutation_iterator_core #(
  parameter int KEY_WORDS = 128,
  parameter int ROUNDS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [6:0] key_index, [38:7] key_word, [39] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] value, [63:32] remaining
  output logic        m_axis_tuser    // [0] exhausted
);

  rpi_pkg::state_e state_q, state_d;
  rpi_pkg::mode_e  mode;

  // configuration; count is stored already saturated
  logic        shuffle_q;
  logic [31:0] start_q, count_q;
  logic [4:0]  bits_q, bits_d;

  logic [31:0] position_q, position_d, walk_q, walk_d;

  // pending result and output register
  logic [31:0] res_value_q, res_value_d, res_rem_q, res_rem_d;
  logic        res_exh_q, res_exh_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q, out_rem_q;
  logic        out_exh_q;

  logic in_acc, cfg_acc, cfg_count_wr, exh, search_go, perm_hit, load_out, is_next;
  logic [31:0] perm_code;
  logic        perm_done;

  rpi_pkg::key_wr_t    key_wr;
  rpi_pkg::perm_ctrl_t perm_ctrl;

  assign mode         = rpi_pkg::mode_e'(s_axis_tuser);
  assign cfg_ready_o  = 1'b1;
  assign cfg_acc      = cfg_valid_i && cfg_ready_o;
  assign cfg_count_wr = cfg_acc && (cfg_index_i == rpi_pkg::CFG_COUNT);
  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign is_next      = in_acc && (mode == rpi_pkg::MODE_NEXT);

  assign exh       = (position_q >= count_q);
  assign search_go = (bits_q != rpi_pkg::BITS_MAX) && (count_q > (32'h1 << bits_q));
  assign perm_hit  = perm_done && (perm_code < count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpi_pkg::ST_IDLE: begin
        if (is_next) begin
          state_d = (exh || !shuffle_q) ? rpi_pkg::ST_DONE : rpi_pkg::ST_PERM;
        end
      end
      rpi_pkg::ST_SEARCH: begin
        if (!search_go) begin
          state_d = rpi_pkg::ST_IDLE;
        end
      end
      rpi_pkg::ST_PERM: begin
        if (perm_hit) begin
          state_d = rpi_pkg::ST_DONE;
        end
      end
      rpi_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = rpi_pkg::ST_IDLE;
        end
      end
      default: state_d = rpi_pkg::ST_IDLE;
    endcase
    // a new count always re-derives the domain width
    if (cfg_count_wr) begin
      state_d = rpi_pkg::ST_SEARCH;
    end
  end

  // FSM outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      rpi_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      rpi_pkg::ST_DONE:   load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    position_d  = position_q;
    walk_d      = walk_q;
    bits_d      = bits_q;
    res_value_d = res_value_q;
    res_rem_d   = res_rem_q;
    res_exh_d   = res_exh_q;

    key_wr.en    = 1'b0;
    key_wr.index = s_axis_tdata[6:0];
    key_wr.word  = s_axis_tdata[38:7];

    perm_ctrl.start = 1'b0;
    perm_ctrl.seed  = walk_q;
    perm_ctrl.bits  = bits_q;

    if (in_acc) begin
      unique case (mode)
        rpi_pkg::MODE_KEY: key_wr.en = 1'b1;
        rpi_pkg::MODE_RESTART: begin
          position_d = '0;
          walk_d     = '0;
        end
        rpi_pkg::MODE_NEXT: begin
          if (exh) begin
            res_value_d = '0;
            res_rem_d   = '0;
            res_exh_d   = 1'b1;
          end else begin
            position_d = position_q + 32'd1;
            res_rem_d  = count_q + ~position_q;  // count - (position + 1)
            res_exh_d  = 1'b0;
            if (shuffle_q) begin
              perm_ctrl.start = 1'b1;
            end else if (walk_q < count_q) begin
              res_value_d = start_q + walk_q;
              walk_d      = walk_q + 32'd1;
            end else begin
              // walk ran past a shrunk count: wrap to the first member
              res_value_d = start_q;
              walk_d      = 32'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // each finished try consumes one walk value; misses try the next one
    if ((state_q == rpi_pkg::ST_PERM) && perm_done) begin
      walk_d = walk_q + 32'd1;
      if (perm_hit) begin
        res_value_d = start_q + perm_code;
      end else begin
        perm_ctrl.start = 1'b1;
        perm_ctrl.seed  = walk_q + 32'd1;
      end
    end

    if ((state_q == rpi_pkg::ST_SEARCH) && search_go) begin
      bits_d = bits_q + 5'd1;
    end
    if (cfg_count_wr) begin
      bits_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  rpi_perm #(
    .KEY_WORDS (KEY_WORDS),
    .ROUNDS    (ROUNDS)
  ) u_perm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_wr_i (key_wr),
    .ctrl_i   (perm_ctrl),
    .done_o   (perm_done),
    .code_o   (perm_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpi_pkg::ST_IDLE;
      shuffle_q   <= 1'b0;
      start_q     <= '0;
      count_q     <= 32'd1;
      bits_q      <= '0;
      position_q  <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      position_q  <= position_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_acc) begin
        unique case (cfg_index_i)
          rpi_pkg::CFG_SHUFFLE: shuffle_q <= cfg_data_i[0];
          rpi_pkg::CFG_START:   start_q   <= cfg_data_i;
          rpi_pkg::CFG_COUNT: begin
            count_q <= (cfg_data_i > rpi_pkg::COUNT_MAX) ? rpi_pkg::COUNT_MAX : cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q <= res_value_d;
    res_rem_q   <= res_rem_d;
    res_exh_q   <= res_exh_d;
    if (load_out) begin
      out_value_q <= res_value_q;
      out_rem_q   <= res_rem_q;
      out_exh_q   <= res_exh_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rem_q, out_value_q};
  assign m_axis_tuser  = out_exh_q;

endmodule

// ----- rtl/rpi_perm.sv -----
// Keyed permutation unit: key memory plus one cipher round per cycle.
// Depends on rpi_pkg.
module rpi_perm #(
  parameter int KEY_WORDS = 128,
  parameter int ROUNDS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpi_pkg::key_wr_t    key_wr_i,
  input  rpi_pkg::perm_ctrl_t ctrl_i,
  output logic                done_o,
  output logic [31:0]         code_o
);

  localparam int AW  = $clog2(KEY_WORDS);
  localparam int KB  = $clog2(KEY_WORDS + 1) - 1;  // floor(log2)
  localparam int RCW = $clog2(ROUNDS + 1);
  localparam logic [RCW-1:0] LAST_ROUND = RCW'(ROUNDS - 1);

  logic [31:0] mem [KEY_WORDS];
  logic [31:0] rdata_q;

  logic           busy_q, done_q;
  logic [RCW-1:0] round_q;
  logic [31:0]    code_q, sum_q;

  logic [4:0]  left, right, kshift;
  logic [31:0] mask, kmask, mixed, code_d, sum_nx, raddr_full, k32;
  logic [AW-1:0] raddr, waddr;
  logic        wr_ok, last;

  // domain split: left half rotates in, key shift capped by table size
  assign left   = {1'b0, ctrl_i.bits[4:1]};
  assign right  = ctrl_i.bits - left;
  assign kshift = (left > 5'(KB)) ? 5'(KB) : left;
  assign mask   = (32'h1 << ctrl_i.bits) - 32'h1;
  assign kmask  = (32'h1 << kshift) - 32'h1;

  assign sum_nx = sum_q + rpi_pkg::TEA_DELTA;
  assign mixed  = ((code_q ^ (rdata_q << kshift)) + sum_q) & mask;
  assign code_d = ((mixed << left) | (mixed >> right)) & mask;
  assign last   = (round_q == LAST_ROUND);

  // address of the next round's key word, or the first round's on start
  assign raddr_full = ctrl_i.start ? ((ctrl_i.seed ^ rpi_pkg::TEA_DELTA) & kmask)
                                   : ((code_d ^ sum_nx) & kmask);
  assign raddr = raddr_full[AW-1:0];

  assign k32   = {25'b0, key_wr_i.index};
  assign wr_ok = key_wr_i.en && (k32 < 32'(KEY_WORDS));
  assign waddr = k32[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[waddr] <= key_wr_i.word;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      done_q <= busy_q && last;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          round_q <= round_q + RCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      code_q <= ctrl_i.seed;
      sum_q  <= rpi_pkg::TEA_DELTA;
    end else if (busy_q) begin
      code_q <= code_d;
      sum_q  <= sum_nx;
    end
  end

  assign done_o = done_q;
  assign code_o = code_q;

endmodule

// ----- rtl/rpi_checker.sv -----
// Port-level checks for the range permutation iterator core, bound to it.
// Depends on rpi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // exhausted answers carry zero value and remaining
  `ASSERT_IMPLY(a_exh_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'h0)

  // remaining after a produced member stays below the saturated count
  `ASSERT_IMPLY(a_rem_range, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:32] < rpi_pkg::COUNT_MAX)

  // a count write starts the width search, which blocks requests
  `ASSERT_NEXT(a_count_busy, clk_i, rst_ni, cfg_valid_i && cfg_ready_o && cfg_index_i == rpi_pkg::CFG_COUNT, !s_axis_tready)

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind range_permutation_iterator_core rpi_checker u_rpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/range_permutation_iterator_core_tb.sv -----
// Self-checking bench for range_permutation_iterator_core: directed script, then random traffic.
// Depends on rpi_pkg and the core RTL; an in-bench walk model predicts every result the script does not type in.
module range_permutation_iterator_core_tb;

  localparam int          KEY_WORDS     = 128;
  localparam int          ROUNDS        = 32;
  localparam int unsigned KEY_BITS      = 7;     // floor(log2(KEY_WORDS))
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int          RANDOM_ITEMS  = 420;
  localparam int          LONG_HOLD     = 300;
  localparam int          IDLE_LIMIT    = 3000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 80;
  localparam int          PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [31:0] value;
    logic        exhausted;
    logic [31:0] remaining;
  } member_t;

  typedef struct packed {
    bit      hit;
    member_t m;
  } walk_step_t;

  typedef struct packed {
    bit                 is_cfg;
    rpi_pkg::cfg_idx_e  ci;
    logic [31:0]        cd;
    logic [1:0]         md;
    logic [6:0]         ki;
    logic [31:0]        kw;
    bit                 typed;
    member_t            want;
  } script_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = rpi_pkg::CFG_SHUFFLE;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = rpi_pkg::MODE_KEY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  // expectation typed into the script, travels with the request
  bit      typed_chk = 1'b0;
  member_t typed_res = '0;

  // walk model state
  logic [31:0] key_mem [KEY_WORDS];
  logic [31:0] walk_pos   = '0;
  logic [31:0] walk_ctr   = '0;
  logic        shuf_on    = 1'b0;
  logic [31:0] rng_start  = '0;
  logic [31:0] rng_count  = 32'd1;

  member_t     pending_members [$];
  script_row_t script [$];

  int  mismatches = 0, results_seen = 0, cfg_writes = 0, idle_cycles = 0;
  int  n_next = 0, n_key = 0, n_restart = 0, n_unused = 0;
  int  hold_asks = 0, holds_done = 0;
  bit  steady = 1'b0;

  range_permutation_iterator_core #(
    .KEY_WORDS(KEY_WORDS),
    .ROUNDS   (ROUNDS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Keyed variable-width cipher over the smallest power-of-two domain holding cnt.
  function automatic logic [31:0] tea_scramble(logic [31:0] code_in, logic [31:0] cnt);
    int unsigned nbits, lft, rgt, ksh;
    logic [31:0] code, sum, dmask, kmask, kidx;
    nbits = 0;
    while (nbits < 31 && cnt > (32'd1 << nbits)) nbits++;
    lft   = nbits / 2;
    rgt   = nbits - lft;
    dmask = (32'd1 << nbits) - 32'd1;
    ksh   = (lft > KEY_BITS) ? KEY_BITS : lft;
    kmask = (32'd1 << ksh) - 32'd1;
    sum   = '0;
    code  = code_in;
    for (int r = 0; r < ROUNDS; r++) begin
      sum  = sum + rpi_pkg::TEA_DELTA;
      kidx = (code ^ sum) & kmask;
      code = code ^ (key_mem[kidx[6:0]] << ksh);
      code = (code + sum) & dmask;
      code = ((code << lft) | (code >> rgt)) & dmask;
    end
    return code;
  endfunction

  // Applies one request to the model; hit is set when a result is due.
  function automatic walk_step_t advance_walk(logic [1:0] md, logic [6:0] ki, logic [31:0] kw);
    walk_step_t  st;
    logic [31:0] cnt, idx;
    st = '0;
    case (md)
      rpi_pkg::MODE_KEY: key_mem[ki] = kw;
      rpi_pkg::MODE_RESTART: begin
        walk_pos = '0;
        walk_ctr = '0;
      end
      rpi_pkg::MODE_NEXT: begin
        st.hit = 1'b1;
        cnt = (rng_count > rpi_pkg::COUNT_MAX) ? rpi_pkg::COUNT_MAX : rng_count;
        if (walk_pos >= cnt) begin
          st.m.exhausted = 1'b1;
        end else begin
          walk_pos = walk_pos + 32'd1;
          if (shuf_on) begin
            idx = cnt;
            while (idx >= cnt) begin
              idx      = tea_scramble(walk_ctr, cnt);
              walk_ctr = walk_ctr + 32'd1;
            end
          end else if (walk_ctr < cnt) begin
            idx      = walk_ctr;
            walk_ctr = walk_ctr + 32'd1;
          end else begin
            // counter ran past a shrunk range: wrap to the first index
            idx      = '0;
            walk_ctr = 32'd1;
          end
          st.m.value     = rng_start + idx;
          st.m.remaining = cnt - walk_pos;
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  // Monitor: config and requests feed the model, results are checked in order.
  always @(posedge clk_i) begin : monitor
    walk_step_t st;
    member_t    want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rpi_pkg::CFG_SHUFFLE: shuf_on   = cfg_data_i[0];
          rpi_pkg::CFG_START:   rng_start = cfg_data_i;
          rpi_pkg::CFG_COUNT:   rng_count = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_members.size() == 0) begin
          flag_mismatch("unrequested result, value", m_axis_tdata[31:0], '0);
        end else begin
          want = pending_members.pop_front();
          if (m_axis_tdata[31:0] !== want.value)
            flag_mismatch("value", m_axis_tdata[31:0], want.value);
          if (m_axis_tuser !== want.exhausted)
            flag_mismatch("exhausted", {31'b0, m_axis_tuser}, {31'b0, want.exhausted});
          if (m_axis_tdata[63:32] !== want.remaining)
            flag_mismatch("remaining", m_axis_tdata[63:32], want.remaining);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        st = advance_walk(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[38:7]);
        if (st.hit) pending_members.push_back(typed_chk ? typed_res : st.m);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               idle_cycles, pending_members.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Result sink: random back-pressure, plus a long hold when asked.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_req(logic [1:0] md, logic [6:0] ki, logic [31:0] kw, bit chk,
                          member_t want);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {1'b0, kw, ki};
    typed_chk     <= chk;
    typed_res     <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (md)
      rpi_pkg::MODE_KEY:     n_key++;
      rpi_pkg::MODE_RESTART: n_restart++;
      rpi_pkg::MODE_NEXT:    n_next++;
      default:               n_unused++;
    endcase
  endtask

  // Stop offering, let every expected result drain, then let trailing requests finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_members.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(rpi_pkg::cfg_idx_e ci, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ci;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic void script_cfg(rpi_pkg::cfg_idx_e ci, logic [31:0] d);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.ci = ci;
    row.cd = d;
    script.push_back(row);
  endfunction

  function automatic void script_req(logic [1:0] md, logic [6:0] ki, logic [31:0] kw);
    script_row_t row;
    row = '0;
    row.md = md;
    row.ki = ki;
    row.kw = kw;
    script.push_back(row);
  endfunction

  // next request whose result is known up front
  function automatic void script_next(logic [31:0] value, logic exh, logic [31:0] rem);
    script_row_t row;
    row = '0;
    row.md = rpi_pkg::MODE_NEXT;
    row.typed = 1'b1;
    row.want.value = value;
    row.want.exhausted = exh;
    row.want.remaining = rem;
    script.push_back(row);
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return rpi_pkg::COUNT_MAX;
      3:       return $urandom_range(0, 1) ? rpi_pkg::COUNT_MAX + 32'd1 : 32'hffff_ffff;
      4:       return $urandom();
      5, 6, 7: return $urandom_range(2, 1000);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return rpi_pkg::MODE_NEXT;
    if (r < 84) return rpi_pkg::MODE_KEY;
    if (r < 94) return rpi_pkg::MODE_RESTART;
    return MODE_UNUSED;
  endfunction

  initial begin : stimulus
    int          random_items, phase, burst;
    logic [1:0]  md;
    script_row_t row;

    // After reset: sequential, start 0, count 1.
    script_next(32'h0, 1'b0, 32'h0);
    script_next(32'h0, 1'b1, 32'h0);
    script_req(MODE_UNUSED, 7'd127, 32'hffff_ffff);
    script_req(rpi_pkg::MODE_RESTART, 7'd0, 32'h0);
    script_next(32'h0, 1'b0, 32'h0);
    // start at the top of the space: second member wraps to zero
    script_cfg(rpi_pkg::CFG_START, 32'hffff_ffff);
    script_cfg(rpi_pkg::CFG_COUNT, 32'd2);
    script_next(32'h0, 1'b0, 32'h0);
    script_next(32'h0, 1'b1, 32'h0);
    // empty range
    script_cfg(rpi_pkg::CFG_COUNT, 32'd0);
    script_req(rpi_pkg::MODE_RESTART, 7'd0, 32'h0);
    script_next(32'h0, 1'b1, 32'h0);
    // oversized count saturates
    script_cfg(rpi_pkg::CFG_COUNT, 32'hffff_ffff);
    script_cfg(rpi_pkg::CFG_START, 32'h0000_1000);
    script_req(rpi_pkg::MODE_RESTART, 7'd0, 32'h0);
    script_next(32'h0000_1000, 1'b0, 32'h7fff_ffff);
    script_next(32'h0000_1001, 1'b0, 32'h7fff_fffe);
    // key words, including those that small shuffled domains read
    script_req(rpi_pkg::MODE_KEY, 7'd0, 32'hffff_ffff);
    script_req(rpi_pkg::MODE_KEY, 7'd1, 32'ha5a5_5a5a);
    script_req(rpi_pkg::MODE_KEY, 7'd127, 32'h0);
    // single-member shuffled range always yields index zero
    script_cfg(rpi_pkg::CFG_SHUFFLE, 32'd1);
    script_cfg(rpi_pkg::CFG_COUNT, 32'd1);
    script_req(rpi_pkg::MODE_RESTART, 7'd0, 32'h0);
    script_next(32'h0000_1000, 1'b0, 32'h0);
    script_next(32'h0, 1'b1, 32'h0);
    // domain of four with one code skipped by cycle walking
    script_cfg(rpi_pkg::CFG_COUNT, 32'd3);
    script_cfg(rpi_pkg::CFG_START, 32'h0);
    script_req(rpi_pkg::MODE_RESTART, 7'd0, 32'h0);
    script_req(rpi_pkg::MODE_NEXT, 7'd0, 32'h0);
    script_req(rpi_pkg::MODE_NEXT, 7'd0, 32'h0);
    script_req(rpi_pkg::MODE_NEXT, 7'd0, 32'h0);
    script_next(32'h0, 1'b1, 32'h0);
    // walk counter likely past the position: sequential walk may wrap
    script_cfg(rpi_pkg::CFG_SHUFFLE, 32'd0);
    script_cfg(rpi_pkg::CFG_COUNT, 32'd4);
    script_req(rpi_pkg::MODE_NEXT, 7'd0, 32'h0);

    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        settle();
        cfg_write(row.ci, row.cd);
      end else begin
        send_req(row.md, row.ki, row.kw, row.typed, row.want);
      end
    end

    // Fill the whole key table so wide shuffled domains never read an unwritten word.
    for (int k = 0; k < KEY_WORDS; k++)
      send_req(rpi_pkg::MODE_KEY, k[6:0], $urandom(), 1'b0, '0);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        settle();
        if (phase == 0 || $urandom_range(0, 1) == 0)
          cfg_write(rpi_pkg::CFG_SHUFFLE, phase == 0 ? 32'd1 : $urandom());
        if (phase == 0 || $urandom_range(0, 1) == 0)
          cfg_write(rpi_pkg::CFG_COUNT, phase == 0 ? rpi_pkg::COUNT_MAX : pick_count());
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 3))
            0:       cfg_write(rpi_pkg::CFG_START, 32'h0);
            1:       cfg_write(rpi_pkg::CFG_START, 32'hffff_ffff);
            default: cfg_write(rpi_pkg::CFG_START, $urandom());
          endcase
        end
      end
      steady = ($urandom_range(0, 4) == 0);
      // one stretch where the sink holds off and the core backs up
      if (phase == 3) hold_asks++;
      // mostly start a fresh walk; otherwise carry on with the old position
      if ($urandom_range(0, 3) != 0) begin
        send_req(rpi_pkg::MODE_RESTART, 7'($urandom_range(0, 127)), $urandom(), 1'b0, '0);
        random_items++;
      end
      burst = (phase == 3) ? 16 : $urandom_range(4, 30);
      repeat (burst) begin
        md = (phase == 3) ? rpi_pkg::MODE_NEXT : pick_mode();
        send_req(md, 7'($urandom_range(0, 127)), $urandom(), 1'b0, '0);
        if (md != MODE_UNUSED) random_items++;
      end
      phase++;
    end

    settle();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d next, %0d key loads, %0d restarts, %0d unused mode",
             n_next + n_key + n_restart + n_unused, n_next, n_key, n_restart, n_unused);
    $display("%0d results checked over %0d register writes, %0d mismatches",
             results_seen, cfg_writes, mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
